### src/tbfg_pkg.sv
package tbfg_pkg;

   // Frame geometry.
   localparam int FRAME_BYTES = 40;
   localparam int CRC_SPAN    = 36;
   localparam int IDX_W       = 6;
   localparam logic [IDX_W-1:0] LAST_INDEX  = IDX_W'(FRAME_BYTES - 1);
   localparam logic [IDX_W-1:0] CRC_INDEX   = IDX_W'(CRC_SPAN);
   localparam logic [IDX_W-1:0] HDR_TOP     = IDX_W'(CRC_SPAN - 1);

   // Fixed frame header values.
   localparam logic [31:0] MAGIC_WORD    = 32'h5A545331;
   localparam logic [7:0]  FRAME_VERSION = 8'h01;
   localparam logic [7:0]  FRAME_TYPE    = 8'h01;
   localparam logic [15:0] FRAME_LENGTH  = 16'(FRAME_BYTES);

   // CRC-32, reflected form.
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // Configuration register indexes and widths.
   localparam int CSR_ADDR_W = 1;
   localparam int PERIOD_W   = 40;
   localparam logic [CSR_ADDR_W-1:0] REG_ENABLE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_PERIOD = 1'b1;
   localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 40'd1000000000;

   // Operation codes carried in the request tuser.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // Port widths.
   localparam int REQ_DATA_W = 248;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [1:0] {
      ST_DISABLED  = 2'd0,
      ST_WAIT_LINK = 2'd1,
      ST_READY     = 2'd2,
      ST_TX_ERROR  = 2'd3
   } status_type;

   // One input transaction, unpacked.
   typedef struct packed {
      logic        op;
      logic        link_up;
      logic        channel_open;
      logic [63:0] now_ns;
      logic [63:0] veh_clock_ns;
      logic [63:0] wall_clock_ns;
      logic [7:0]  wall_valid;
      logic [7:0]  clock_origin;
      logic [31:0] sync_word;
      logic        sent_ok;
   } item_type;

   // Work handed from the front to the back through the queue.
   typedef struct packed {
      logic        is_frame;
      status_type  status;
      logic [31:0] tx_count;
      logic [31:0] sequence_no;
      logic [63:0] veh_clock_ns;
      logic [63:0] wall_clock_ns;
      logic [7:0]  wall_valid;
      logic [7:0]  clock_origin;
      logic [31:0] sync_word;
   } job_type;

   // Fold one byte into the reflected CRC register.
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] acc;
      acc = crc ^ {24'b0, data};
      for (int k = 0; k < 8; k++) begin
         acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

endpackage

### src/time_broadcast_frame_generator_core.sv
// Path: an accepted request transaction is written into the job queue, and the back end
// then moves its results from the queue head into the output register.
// Throughput: one request per cycle while the job queue has room; the back end emits one
// result per cycle unless rsp_tready stalls it; status-only gives one result, a frame 40.
// Reset (synchronous, active high): enable on, period 1 s, deadline unarmed, counters
// zero, status wait_link, job queue and output register empty.
module time_broadcast_frame_generator_core import tbfg_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata from bit 0: link_up, channel_open, now_ns, veh_clock_ns, wall_clock_ns,
   // wall_valid, clock_origin, sync_word, sent_ok, zero fill.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: op.
   input  logic                  req_tuser,
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata from bit 0: frame_byte, byte_index, status, tx_count.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: frame_valid.
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   // Configuration write port.
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [PERIOD_W-1:0]   csr_wdata
);

   item_type item;
   job_type  push_job;
   job_type  head_job;
   logic     push;
   logic     full;
   logic     pop;
   logic     head_valid;

   // Unpack the request transaction.
   assign item.link_up       = req_tdata[0];
   assign item.channel_open  = req_tdata[1];
   assign item.now_ns        = req_tdata[65:2];
   assign item.veh_clock_ns  = req_tdata[129:66];
   assign item.wall_clock_ns = req_tdata[193:130];
   assign item.wall_valid    = req_tdata[201:194];
   assign item.clock_origin  = req_tdata[209:202];
   assign item.sync_word     = req_tdata[241:210];
   assign item.sent_ok       = req_tdata[242];
   assign item.op            = req_tuser;

   tbfg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .item_valid (req_tvalid),
      .item       (item),
      .queue_full (full),
      .item_ready (req_tready),
      .push       (push),
      .job        (push_job)
   );

   tbfg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tbfg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (head_valid),
      .job        (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### src/tbfg_front.sv
module tbfg_front import tbfg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [PERIOD_W-1:0]   csr_wdata,
   input  logic                  item_valid,
   input  item_type              item,
   input  logic                  queue_full,
   output logic                  item_ready,
   output logic                  push,
   output job_type               job
);

   logic                enable_ff, enable_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [63:0]         deadline_ff, deadline_in;
   logic [31:0]         sequence_ff, sequence_in;
   logic [31:0]         sent_ff, sent_in;
   status_type          status_ff, status_in;
   logic [63:0]         renew_sum;
   logic                is_frame;

   assign item_ready = !queue_full;
   assign push       = item_valid && !queue_full;
   assign renew_sum  = item.now_ns + {{(64 - PERIOD_W){1'b0}}, period_ff};

   // Register writes and transaction classification.
   always_comb begin
      enable_in   = enable_ff;
      period_in   = period_ff;
      deadline_in = deadline_ff;
      sequence_in = sequence_ff;
      sent_in     = sent_ff;
      status_in   = status_ff;
      is_frame    = 1'b0;
      if (csr_we) begin
         unique case (csr_addr)
            REG_ENABLE: begin
               if (!csr_wdata[0]) begin
                  status_in = ST_DISABLED;
               end else if (!enable_ff) begin
                  status_in   = ST_WAIT_LINK;
                  deadline_in = '0;
               end
               enable_in = csr_wdata[0];
            end
            REG_PERIOD: begin
               period_in = csr_wdata;
            end
            default: begin
               period_in = period_ff;
            end
         endcase
      end else if (push) begin
         priority if (!enable_ff) begin
            status_in = ST_DISABLED;
         end else if (item.op == OP_REPORT) begin
            if (item.sent_ok) begin
               sequence_in = sequence_ff + 32'd1;
               sent_in     = sent_ff + 32'd1;
               status_in   = ST_READY;
            end else begin
               status_in = ST_TX_ERROR;
            end
         end else if (!item.link_up) begin
            deadline_in = '0;
            status_in   = ST_WAIT_LINK;
         end else if (deadline_ff == '0) begin
            deadline_in = renew_sum;
         end else if (item.now_ns >= deadline_ff) begin
            deadline_in = renew_sum;
            is_frame    = item.channel_open;
         end else begin
            // A tick before the deadline leaves the state as it is.
            deadline_in = deadline_ff;
         end
      end
   end

   // Job holds the post-transaction state, but sequence_no from before.
   always_comb begin
      job.is_frame      = is_frame;
      job.status        = status_in;
      job.tx_count      = sent_in;
      job.sequence_no   = sequence_ff;
      job.veh_clock_ns  = item.veh_clock_ns;
      job.wall_clock_ns = item.wall_clock_ns;
      job.wall_valid    = item.wall_valid;
      job.clock_origin  = item.clock_origin;
      job.sync_word     = item.sync_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         period_ff   <= PERIOD_RESET;
         deadline_ff <= '0;
         sequence_ff <= '0;
         sent_ff     <= '0;
         status_ff   <= ST_WAIT_LINK;
      end else begin
         enable_ff   <= enable_in;
         period_ff   <= period_in;
         deadline_ff <= deadline_in;
         sequence_ff <= sequence_in;
         sent_ff     <= sent_in;
         status_ff   <= status_in;
      end
   end

endmodule

### src/tbfg_queue.sv
module tbfg_queue import tbfg_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type           slots [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_job   = slots[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/tbfg_back.sv
module tbfg_back import tbfg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  job_type               job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic [CRC_SPAN-1:0][7:0] hdr_bytes;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [31:0]       crc_ff, crc_in;
   logic [31:0]       crc_base;
   logic [31:0]       crc_out;
   logic [7:0]        cur_byte;
   logic              advance;
   logic              at_last;

   logic              valid_ff, valid_in;
   logic              fvalid_ff, fvalid_in;
   logic [7:0]        byte_ff, byte_in;
   logic [IDX_W-1:0]  oidx_ff, oidx_in;
   logic              last_ff, last_in;
   status_type        status_ff, status_in;
   logic [31:0]       count_ff, count_in;

   // Header bytes, byte 0 in the top element.
   assign hdr_bytes = {MAGIC_WORD, FRAME_VERSION, FRAME_TYPE, FRAME_LENGTH,
                       job.sequence_no, job.veh_clock_ns, job.wall_clock_ns,
                       job.wall_valid, job.clock_origin, 16'h0000, job.sync_word};

   assign advance  = job_valid && (!valid_ff || rsp_tready);
   assign at_last  = (idx_ff == LAST_INDEX);
   assign crc_base = (idx_ff == '0) ? CRC_INIT : crc_ff;
   assign crc_out  = ~crc_ff;

   // Pick the byte at the current position of the frame.
   always_comb begin
      if (idx_ff < CRC_INDEX) begin
         cur_byte = hdr_bytes[HDR_TOP - idx_ff];
      end else begin
         unique case (idx_ff[1:0])
            2'd0:    cur_byte = crc_out[31:24];
            2'd1:    cur_byte = crc_out[23:16];
            2'd2:    cur_byte = crc_out[15:8];
            default: cur_byte = crc_out[7:0];
         endcase
      end
   end

   // Result sequencing into the output register.
   always_comb begin
      pop       = 1'b0;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      valid_in  = valid_ff && !rsp_tready;
      fvalid_in = fvalid_ff;
      byte_in   = byte_ff;
      oidx_in   = oidx_ff;
      last_in   = last_ff;
      status_in = status_ff;
      count_in  = count_ff;
      if (advance) begin
         valid_in  = 1'b1;
         status_in = job.status;
         count_in  = job.tx_count;
         if (!job.is_frame) begin
            pop       = 1'b1;
            fvalid_in = 1'b0;
            byte_in   = '0;
            oidx_in   = '0;
            last_in   = 1'b1;
         end else begin
            pop       = at_last;
            fvalid_in = 1'b1;
            byte_in   = cur_byte;
            oidx_in   = idx_ff;
            last_in   = at_last;
            idx_in    = at_last ? '0 : idx_ff + 1'b1;
            if (idx_ff < CRC_INDEX) begin
               crc_in = crc_fold(crc_base, cur_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff    <= crc_in;
      fvalid_ff <= fvalid_in;
      byte_ff   <= byte_in;
      oidx_ff   <= oidx_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      count_ff  <= count_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = fvalid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {count_ff, status_ff, oidx_ff, byte_ff};

`ifndef SYNTHESIS
   // Mid-frame, the frame being sent must still sit at the queue head.
   assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> (job_valid && job.is_frame))
      else $error("frame position advanced without a frame job at the head");

   // A frame byte closes the transaction exactly at the final position.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && fvalid_ff) |-> (last_ff == (oidx_ff == LAST_INDEX)))
      else $error("frame last flag does not match the final byte position");

   // A status-only result is a single, closing result at position zero.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !fvalid_ff) |-> (last_ff && oidx_ff == '0 && byte_ff == '0))
      else $error("status-only result malformed");

   // The head job is released only together with a closing result.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff))
      else $error("job released without a closing result");
`endif

endmodule
